[rtl/sliding_median_filter_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sliding median filter
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MEDIAN_FILTER_DEFINES_SVH
`define SLIDING_MEDIAN_FILTER_DEFINES_SVH

// condition holds at every edge
`define SMF_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SMF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/smf_pkg.sv]
// ----------------------------------------------------------------------------
// Sliding median filter package
// Sizes, item types and window helper shared by the filter modules.
// ----------------------------------------------------------------------------
package smf_pkg;

    localparam int MAX_WINDOW   = 15;
    localparam int SAMPLE_WIDTH = 16;
    localparam int CFG_WIDTH    = 4;

    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int H_W     = (MAX_WINDOW / 2 > 0) ? $clog2(MAX_WINDOW / 2 + 1) : 1;
    localparam int WIN_CAP = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_WIDTH-1:0] WINDOW_LEN_RESET = CFG_WIDTH'(3);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    typedef struct packed {
        sample_t sample;
        logic    last;
        logic    start;
    } item_t;

    typedef struct packed {
        logic  push;
        item_t item;
    } q_push_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    // odd window length, even requests raised by one, capped at the store size
    function automatic logic [CNT_W-1:0] eff_window(input logic [CFG_WIDTH-1:0] len);
        int w;
        w = int'(len);
        if (!len[0])
            w = w + 1;
        if (w > WIN_CAP)
            w = WIN_CAP;
        return CNT_W'(w);
    endfunction

endpackage

[rtl/smf_if.sv]
// ----------------------------------------------------------------------------
// Sliding median filter channels
// Sample, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface smf_in_if;
    logic             valid;
    logic             ready;
    smf_pkg::sample_t sample;
    logic             end_of_seq;

    modport source (output valid, output sample, output end_of_seq, input ready);
    modport sink   (input valid, input sample, input end_of_seq, output ready);
endinterface

interface smf_out_if;
    logic             valid;
    logic             ready;
    smf_pkg::sample_t median;
    logic             last_out;

    modport source (output valid, output median, output last_out, input ready);
    modport sink   (input valid, input median, input last_out, output ready);
endinterface

interface smf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [smf_pkg::CFG_WIDTH-1:0]    window_len;

    modport source (output valid, output window_len, input ready);
    modport sink   (input valid, input window_len, output ready);
endinterface

[rtl/smf_queue.sv]
// ----------------------------------------------------------------------------
// Sliding median filter item queue
// Short FIFO between the accepting front end and the filtering back end.
// ----------------------------------------------------------------------------
module smf_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  smf_pkg::q_push_t wr,
    output logic             full,
    output smf_pkg::q_head_t head,
    input  logic             pop
);
    import smf_pkg::*;

    item_t              mem_reg [Q_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_pop;

    assign full       = (count_reg == QCNT_W'(Q_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr.push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!wr.push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
            mem_reg[wr_ptr_reg] <= wr.item;
    end

endmodule

[rtl/smf_front.sv]
// ----------------------------------------------------------------------------
// Sliding median filter front end
// Accept sample words and tag the first word of each sequence.
// ----------------------------------------------------------------------------
module smf_front (
    input  logic             clk,
    input  logic             rst_n,
    smf_in_if.sink           samples,
    input  logic             q_full,
    output smf_pkg::q_push_t wr
);
    import smf_pkg::*;

    logic in_seq_reg, in_seq_next;

    assign samples.ready  = !q_full;
    assign wr.push        = samples.valid && !q_full;
    assign wr.item.sample = samples.sample;
    assign wr.item.last   = samples.end_of_seq;
    assign wr.item.start  = !in_seq_reg;

    // a sequence stays open until its final word
    always_comb
    begin
        in_seq_next = in_seq_reg;
        if (wr.push)
            in_seq_next = !samples.end_of_seq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_seq_reg <= 1'b0;
        else
            in_seq_reg <= in_seq_next;
    end

endmodule

[rtl/smf_back.sv]
// ----------------------------------------------------------------------------
// Sliding median filter back end
// Window shift store, rank search for the median and flush sequencing.
// ----------------------------------------------------------------------------
`include "sliding_median_filter_defines.svh"

module smf_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [smf_pkg::CFG_WIDTH-1:0] window_len,
    input  smf_pkg::q_head_t              head,
    output logic                          pop,
    smf_out_if.source                     medians
);
    import smf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT,
        S_FLUSH
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_WINDOW - 1);

    state_t             state_reg, state_next;
    sample_t            store_reg [MAX_WINDOW];
    logic [CNT_W-1:0]   seen_reg, seen_next;
    sample_t            x_reg, x_next;
    logic               last_reg, last_next;
    logic [H_W-1:0]     h_reg, h_next;
    logic [IDX_W-1:0]   win_lo_reg, win_lo_next;
    logic [H_W-1:0]     flush_reg, flush_next;
    logic [H_W-1:0]     r_reg, r_next;
    logic [IDX_W-1:0]   cand_reg, cand_next;
    sample_t            med_reg, med_next;
    logic               out_valid_reg, out_valid_next;
    sample_t            median_reg, median_next;
    logic               last_out_reg, last_out_next;

    logic               store_fill;
    logic               store_shift;
    sample_t            shift_in;

    logic [CNT_W-1:0]   w_new;
    logic [H_W-1:0]     h_new;
    logic [IDX_W-1:0]   win_lo_new;
    logic [CNT_W-1:0]   seen_inc;
    logic               emit_now;
    logic               emit_flush;

    sample_t            cand_val;
    logic [MAX_WINDOW-1:0] lt_vec;
    logic [MAX_WINDOW-1:0] le_vec;
    logic [CNT_W-1:0]   lt_cnt;
    logic [CNT_W-1:0]   le_cnt;
    logic               hit;

    logic               out_free;
    logic               load_out;

    assign medians.valid    = out_valid_reg;
    assign medians.median   = median_reg;
    assign medians.last_out = last_out_reg;
    assign out_free         = !out_valid_reg || medians.ready;

    // window geometry for a freshly popped word
    assign w_new      = eff_window(window_len);
    assign h_new      = H_W'((w_new - 1'b1) >> 1);
    assign win_lo_new = IDX_W'(MAX_WINDOW - int'(w_new));
    assign seen_inc   = (seen_reg < CNT_W'(MAX_WINDOW)) ? seen_reg + 1'b1 : seen_reg;
    assign emit_now   = int'(seen_inc) >= int'(h_new) + 1;
    assign emit_flush = int'(seen_reg) + int'(r_reg) + 1 >= int'(h_reg) + 1;

    // rank test of one candidate against the live part of the window
    assign cand_val = store_reg[cand_reg];

    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            lt_vec[i] = (i >= int'(win_lo_reg)) && (store_reg[i] <  cand_val);
            le_vec[i] = (i >= int'(win_lo_reg)) && (store_reg[i] <= cand_val);
        end
    end

    assign lt_cnt = CNT_W'($countones(lt_vec));
    assign le_cnt = CNT_W'($countones(le_vec));
    assign hit    = (int'(lt_cnt) <= int'(h_reg)) && (int'(le_cnt) > int'(h_reg));

    assign shift_in = (state_reg == S_IDLE) ? head.item.sample : x_reg;

    always_comb
    begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        x_next         = x_reg;
        last_next      = last_reg;
        h_next         = h_reg;
        win_lo_next    = win_lo_reg;
        flush_next     = flush_reg;
        r_next         = r_reg;
        cand_next      = cand_reg;
        med_next       = med_reg;
        out_valid_next = out_valid_reg;
        median_next    = median_reg;
        last_out_next  = last_out_reg;
        store_fill     = 1'b0;
        store_shift    = 1'b0;
        pop            = 1'b0;
        load_out       = 1'b0;

        if (out_valid_reg && medians.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop         = 1'b1;
                    x_next      = head.item.sample;
                    last_next   = head.item.last;
                    h_next      = h_new;
                    win_lo_next = win_lo_new;
                    store_fill  = head.item.start;
                    store_shift = !head.item.start;
                    seen_next   = seen_inc;
                    flush_next  = head.item.last ? h_new : '0;
                    r_next      = '0;
                    cand_next   = win_lo_new;
                    if (emit_now)
                        state_next = S_SEARCH;
                    else if (head.item.last && (h_new != '0))
                        state_next = S_FLUSH;
                    else if (head.item.last)
                        seen_next = '0;
                end
            end

            S_SEARCH:
            begin
                if (hit)
                begin
                    med_next   = cand_val;
                    state_next = S_EMIT;
                end
                else
                begin
                    cand_next = cand_reg + 1'b1;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    median_next    = med_reg;
                    last_out_next  = last_reg && (flush_reg == '0);
                    if (flush_reg != '0)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        if (last_reg)
                            seen_next = '0;
                    end
                end
            end

            S_FLUSH:
            begin
                // repeat the final sample to drain the pending outputs
                store_shift = 1'b1;
                r_next      = r_reg + 1'b1;
                flush_next  = flush_reg - 1'b1;
                cand_next   = win_lo_reg;
                if (emit_flush)
                begin
                    state_next = S_SEARCH;
                end
                else if (flush_reg == H_W'(1))
                begin
                    state_next = S_IDLE;
                    seen_next  = '0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seen_reg      <= '0;
            x_reg         <= '0;
            last_reg      <= 1'b0;
            h_reg         <= '0;
            win_lo_reg    <= '0;
            flush_reg     <= '0;
            r_reg         <= '0;
            cand_reg      <= '0;
            med_reg       <= '0;
            out_valid_reg <= 1'b0;
            median_reg    <= '0;
            last_out_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            x_reg         <= x_next;
            last_reg      <= last_next;
            h_reg         <= h_next;
            win_lo_reg    <= win_lo_next;
            flush_reg     <= flush_next;
            r_reg         <= r_next;
            cand_reg      <= cand_next;
            med_reg       <= med_next;
            out_valid_reg <= out_valid_next;
            median_reg    <= median_next;
            last_out_reg  <= last_out_next;
        end
    end

    // window store: newest sample at the top, oldest drops off the bottom
    always_ff @(posedge clk)
    begin
        if (store_fill)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
                store_reg[i] <= shift_in;
        end
        else if (store_shift)
        begin
            for (int i = 0; i < MAX_WINDOW - 1; i++)
                store_reg[i] <= store_reg[i + 1];
            store_reg[MAX_WINDOW - 1] <= shift_in;
        end
    end

    `SMF_ASSERT_IMP(a_cand_in_window, state_reg == S_SEARCH, cand_reg >= win_lo_reg,
        "median candidate below window")
    `SMF_ASSERT_IMP(a_search_ends, (state_reg == S_SEARCH) && (cand_reg == LAST_IDX), hit,
        "median search ran off the store")
    `SMF_ASSERT_IMP(a_flush_bound, state_reg != S_IDLE, flush_reg <= h_reg,
        "flush count exceeds half window")
    `SMF_ASSERT_NEXT(a_last_clears, load_out && last_out_next, seen_reg == '0,
        "sequence count not cleared after final result")

endmodule

[rtl/sliding_median_filter.sv]
// ----------------------------------------------------------------------------
// Sliding median filter
// Running median over an odd window with edge replication and end flush.
// ----------------------------------------------------------------------------
// channel   dir   payload                     handshake
// samples   in    sample[15:0], end_of_seq    valid/ready
// medians   out   median[15:0], last_out      valid/ready
// cfg       in    window_len[3:0]             valid/ready (always ready)
//
// Each word enters the window in the idle state; for each result a rank
// search then tests one candidate after another, and the emit state loads the output register once it is free.
// The end-of-sequence flush repeats the final sample for each pending output.
// Reset clears the control state and sets window_len to 3; the window store
// needs no clearing, as the first word of a sequence fills it.
// A two-word queue lets samples be taken while the back end works or stalls.
// ----------------------------------------------------------------------------
module sliding_median_filter (
    input  logic      clk,
    input  logic      rst_n,
    smf_in_if.sink    samples,
    smf_out_if.source medians,
    smf_cfg_if.sink   cfg
);
    import smf_pkg::*;

    logic [CFG_WIDTH-1:0] window_len_reg, window_len_next;
    q_push_t              q_wr;
    q_head_t              q_head;
    logic                 q_full;
    logic                 q_pop;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        window_len_next = window_len_reg;
        if (cfg.valid)
            window_len_next = cfg.window_len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_len_reg <= WINDOW_LEN_RESET;
        else
            window_len_reg <= window_len_next;
    end

    smf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .q_full  (q_full),
        .wr      (q_wr)
    );

    smf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .full  (q_full),
        .head  (q_head),
        .pop   (q_pop)
    );

    smf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .window_len (window_len_reg),
        .head       (q_head),
        .pop        (q_pop),
        .medians    (medians)
    );

endmodule

[verif/tb_sliding_median_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding median filter testbench
// Feeds sample sequences through the filter under several window lengths and
// random stalls on both sides, predicts the medians with its own windowed sort
// and compares every result word, median and end mark, in order.
// ----------------------------------------------------------------------------
module tb_sliding_median_filter;

    import smf_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int DRAIN_WAIT  = 200;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        sample_t sample;
        logic    end_of_seq;
    } feed_word_t;

    typedef struct packed {
        sample_t median;
        logic    last_out;
    } median_word_t;

    logic clk = 1'b0;
    logic rst_n;

    smf_in_if  in_ch ();
    smf_out_if out_ch ();
    smf_cfg_if cfg_ch ();

    sliding_median_filter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (in_ch),
        .medians (out_ch),
        .cfg     (cfg_ch)
    );

    feed_word_t     sample_feed[$];
    median_word_t   median_q[$];

    // predictor state
    sample_t        win_store[MAX_WINDOW];
    int             seen_samples;
    logic [CFG_WIDTH-1:0] win_len;

    int   src_idle_pct;
    int   snk_idle_pct;
    logic hold_go;
    logic hold_off;
    int   mismatch_count;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int odd_window(logic [CFG_WIDTH-1:0] len);
        int w;
        w = int'(len);
        if (!len[0])
            w = w + 1;
        if (w > MAX_WINDOW)
            w = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;
        return w;
    endfunction

    function automatic void shift_in(sample_t x);
        for (int i = 0; i < MAX_WINDOW - 1; i++)
            win_store[i] = win_store[i + 1];
        win_store[MAX_WINDOW - 1] = x;
    endfunction

    // insertion sort over the newest w samples
    function automatic sample_t window_median(int w);
        sample_t sorted_win[MAX_WINDOW];
        sample_t key;
        int      i;
        int      j;
        for (i = 0; i < w; i++)
            sorted_win[i] = win_store[MAX_WINDOW - w + i];
        for (i = 1; i < w; i++)
        begin
            key = sorted_win[i];
            j = i;
            while (j > 0 && sorted_win[j - 1] > key)
            begin
                sorted_win[j] = sorted_win[j - 1];
                j--;
            end
            sorted_win[j] = key;
        end
        return sorted_win[w / 2];
    endfunction

    function automatic void predict_medians(sample_t x, logic eos);
        sample_t vals[$];
        int      w;
        int      h;
        w = odd_window(win_len);
        h = (w - 1) / 2;
        // first word of a sequence replicates into the whole window
        if (seen_samples == 0)
            for (int i = 0; i < MAX_WINDOW; i++)
                win_store[i] = x;
        shift_in(x);
        if (seen_samples < MAX_WINDOW)
            seen_samples++;
        if (seen_samples >= h + 1)
            vals.push_back(window_median(w));
        if (eos)
        begin
            // flush: repeat the final sample h times
            for (int r = 1; r <= h; r++)
            begin
                shift_in(x);
                if (seen_samples + r >= h + 1)
                    vals.push_back(window_median(w));
            end
            seen_samples = 0;
        end
        for (int k = 0; k < vals.size(); k++)
            median_q.push_back('{vals[k], eos && (k == vals.size() - 1)});
    endfunction

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin : sample_drive
        feed_word_t nxt;
        if (!rst_n)
        begin
            in_ch.valid      <= 1'b0;
            in_ch.sample     <= '0;
            in_ch.end_of_seq <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_medians(in_ch.sample, in_ch.end_of_seq);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (sample_feed.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    nxt = sample_feed.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.sample     <= nxt.sample;
                    in_ch.end_of_seq <= nxt.end_of_seq;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // median monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : median_check
        median_word_t exp_word;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (median_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected word median=%0d last_out=%0b",
                                 $realtime, out_ch.median, out_ch.last_out);
                end
                else
                begin
                    exp_word = median_q.pop_front();
                    if (exp_word.median !== out_ch.median ||
                        exp_word.last_out !== out_ch.last_out)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: median exp=%0d got=%0d, last exp=%0b got=%0b",
                                     $realtime, exp_word.median, out_ch.median,
                                     exp_word.last_out, out_ch.last_out);
                    end
                end
            end
            out_ch.ready <= !hold_off && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin : hold_off_ctl
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : watchdog
        #(CLK_PERIOD * 400000);
        $display("tb_sliding_median_filter: done, errors");
        $finish;
    end

    task automatic put_word(sample_t s, logic eos);
        sample_feed.push_back('{s, eos});
    endtask

    // wait until every word is taken and every median has come back
    task automatic drain();
        @(negedge clk);
        while (sample_feed.size() != 0 || in_ch.valid || median_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_window(logic [CFG_WIDTH-1:0] len);
        @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.window_len <= len;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        win_len      <= len;
    endtask

    function automatic sample_t rand_sample();
        case ($urandom_range(7))
            0:       return sample_t'(16'sh7FFF);
            1:       return sample_t'(16'sh8000);
            2, 3:    return sample_t'(int'($urandom_range(8)) - 4);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // whole sequences, each closed with end_of_seq
    task automatic feed_sequences(int n_items);
        int count;
        int len;
        count = 0;
        @(negedge clk);
        while (count < n_items)
        begin
            case ($urandom_range(9))
                0:       len = 1;
                1:       len = $urandom_range(30, 20);
                default: len = $urandom_range(12, 2);
            endcase
            if (count + len > n_items)
                len = n_items - count;
            for (int i = 0; i < len; i++)
                put_word(rand_sample(), i == len - 1);
            count += len;
        end
    endtask

    initial
    begin : stimulus
        logic [CFG_WIDTH-1:0] phase_cfg[3][3];
        int                   idle_src[3];
        int                   idle_snk[3];
        phase_cfg = '{'{4'd15, 4'd2, 4'd0}, '{4'd0, 4'd14, 4'd0}, '{4'd7, 4'd0, 4'd15}};
        idle_src  = '{9, 63, 0};
        idle_snk  = '{63, 9, 0};
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.sample      = '0;
        in_ch.end_of_seq  = 1'b0;
        out_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.window_len = '0;
        hold_go           = 1'b0;
        hold_off          = 1'b0;
        mismatch_count    = 0;
        seen_samples      = 0;
        win_len           = WINDOW_LEN_RESET;
        src_idle_pct      = 0;
        snk_idle_pct      = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset window of three: extremes, then a one-sample sequence
        @(negedge clk);
        put_word(16'sh7FFF, 1'b0);
        put_word(16'sh8000, 1'b0);
        put_word(16'sh0000, 1'b0);
        put_word(16'shFFFF, 1'b0);
        put_word(16'sh0001, 1'b1);
        put_word(16'sh8000, 1'b1);
        drain();

        // zero length is raised to one
        write_window(4'd0);
        @(negedge clk);
        put_word(16'sh7FFF, 1'b0);
        put_word(16'sh8000, 1'b0);
        put_word(16'sd5, 1'b1);
        drain();

        // widest window, sequence shorter than half of it
        write_window(4'd15);
        @(negedge clk);
        put_word(16'sd100, 1'b0);
        put_word(-16'sd100, 1'b0);
        put_word(16'sd7, 1'b1);
        drain();

        // even length, then widen the window mid-sequence
        write_window(4'd4);
        @(negedge clk);
        put_word(16'sd10, 1'b0);
        put_word(-16'sd20, 1'b0);
        put_word(16'sd30, 1'b0);
        put_word(-16'sd40, 1'b0);
        drain();
        write_window(4'd9);
        @(negedge clk);
        put_word(16'sd50, 1'b0);
        put_word(-16'sd60, 1'b0);
        put_word(16'sd70, 1'b0);
        put_word(16'sd1, 1'b1);
        drain();

        for (int p = 0; p < 3; p++)
        begin
            src_idle_pct = idle_src[p];
            snk_idle_pct = idle_snk[p];
            for (int b = 0; b < 3; b++)
            begin
                if (phase_cfg[p][b] == 4'd0 && !(p == 1 && b == 0))
                    write_window(4'($urandom_range(15)));
                else
                    write_window(phase_cfg[p][b]);
                if (p == 2 && b == 1)
                    hold_go = 1'b1;
                feed_sequences(12);
                drain();
            end
        end

        if (mismatch_count == 0 && median_q.size() == 0)
            $display("tb_sliding_median_filter: done, clean");
        else
            $display("tb_sliding_median_filter: done, errors");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/smf_pkg.sv
rtl/smf_if.sv
rtl/smf_queue.sv
rtl/smf_front.sv
rtl/smf_back.sv
rtl/sliding_median_filter.sv
verif/tb_sliding_median_filter.sv
